### sv/hsc_pkg.sv
package hsc_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_HOLE_X   = 3'd4,
        REG_HOLE_Y   = 3'd5,
        REG_HOLE_Z   = 3'd6,
        REG_COS_HOLE = 3'd7
    } hsc_reg_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_Q14 = 14;
    localparam logic [63:0] HALF_Q14 = 64'd8192;
    localparam logic [30:0] RADIUS_RST = 31'd65536;
    localparam logic [15:0] ONE_Q14 = 16'd16384;
    localparam logic signed [32:0] ONE_SQ_Q28 = 33'sd268435456;

    // Input beat: query point in Q16.16.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } hsc_in_t;

    // Result beat.
    typedef struct packed {
        logic signed [31:0] clearance;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               in_hole;
        logic               degenerate;
    } hsc_out_t;

    // Per-item context carried along the pipeline; fields fill in as it advances.
    typedef struct packed {
        logic [2:0][32:0] d;
        logic [33:0]      len;
        logic [14:0]      s;
        logic             degen;
        logic [2:0][15:0] u;
        logic             hole;
        logic [19:0]      c14;
        logic [35:0]      clr0;
        logic [2:0][34:0] tv;
        logic [2:0][15:0] t;
        logic [2:0][36:0] e;
        logic [37:0]      lenf;
    } hsc_ctx_t;

    // Divide by 2^14, rounding half away from zero.
    function automatic logic signed [63:0] rnd_q14(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] q;
        mag = x[63] ? 64'(-x) : 64'(x);
        q = (mag + HALF_Q14) >> FRAC_Q14;
        return x[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

### sv/holed_sphere_collision_unit.sv
// Throughput: one beat per cycle; every stage advances together when the
// output register is empty or being taken, so a stall holds the whole pipe.
// Depth is set by the three bit-per-stage square root units and the three
// bit-per-stage rounding dividers. Reset (aresetn low, synchronous) clears all
// valid bits and loads the configuration registers with their reset values.
module holed_sphere_collision_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  hsc_pkg::hsc_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output hsc_pkg::hsc_out_t                m_data,
    input  logic                             cfg_wr_en,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import hsc_pkg::*;

    localparam int CTX_W = $bits(hsc_ctx_t);

    // Configuration registers.
    logic [2:0][31:0] center_reg;
    logic [30:0]      radius_reg;
    logic [2:0][15:0] hdir_reg;
    logic [15:0]      cos_reg;

    logic en;

    // Front stages: offset, squares, sums.
    logic             s1_v_reg, s2_v_reg, s3_v_reg;
    logic [2:0][31:0] pt;
    logic [2:0][32:0] s1_d_reg, s1_d_next;
    logic [2:0][32:0] s2_d_reg;
    logic [2:0][65:0] s2_sq_reg, s2_sq_next;
    logic [31:0]      s2_chsq_reg, s2_chsq_next;
    logic [2:0][32:0] s3_d_reg;
    logic [67:0]      s3_n_reg, s3_n_next;
    logic [67:0]      s3_srem_reg, s3_srem_next;

    logic               sq1_v;
    logic [1:0][33:0]   sq1_root;
    logic [98:0]        sq1_side;
    hsc_ctx_t           ctx_a;

    logic               dv1_v;
    logic [2:0][15:0]   dv1_quot;
    logic [CTX_W-1:0]   dv1_side;

    // Middle stages: dot product, cone test, tangent vector.
    logic             s5_v_reg, s6_v_reg, s7_v_reg, s8_v_reg, s9_v_reg, s10_v_reg, s11_v_reg;
    hsc_ctx_t         s5_ctx_reg, s5_ctx_next, s6_ctx_reg, s7_ctx_reg, s7_ctx_next;
    hsc_ctx_t         s8_ctx_reg, s9_ctx_reg, s9_ctx_next, s10_ctx_reg, s11_ctx_reg;
    logic [2:0][31:0] s5_prod_reg, s5_prod_next;
    logic [33:0]      s6_dot_reg, s6_dot_next;
    logic [2:0][34:0] s8_uu_reg, s8_uu_next;
    logic [2:0][35:0] s8_ch_reg, s8_ch_next;
    logic [2:0][69:0] s10_sq_reg, s10_sq_next;
    logic [71:0]      s11_n_reg, s11_n_next;

    logic               sq2_v;
    logic [0:0][35:0]   sq2_root;
    logic [CTX_W-1:0]   sq2_side;
    hsc_ctx_t           ctx_b;
    logic [2:0][48:0]   dv2_num;

    logic               dv2_v;
    logic [2:0][15:0]   dv2_quot;
    logic [CTX_W-1:0]   dv2_side;

    // Back stages: rim point, offsets from rim and pole.
    logic             s12_v_reg, s13_v_reg, s14_v_reg, s15_v_reg, s16_v_reg, s17_v_reg;
    hsc_ctx_t         s12_ctx_reg, s12_ctx_next, s13_ctx_reg, s14_ctx_reg, s15_ctx_reg;
    hsc_ctx_t         s15_ctx_next, s16_ctx_reg, s17_ctx_reg;
    logic [2:0][31:0] s12_m1_reg, s12_m1_next, s12_m2_reg, s12_m2_next;
    logic [2:0][19:0] s13_w_reg, s13_w_next;
    logic [2:0][51:0] s14_rw_reg, s14_rw_next;
    logic [2:0][47:0] s14_rh_reg, s14_rh_next;
    logic [2:0][36:0] s15_f_reg, s15_f_next;
    logic [2:0][73:0] s16_esq_reg, s16_esq_next, s16_fsq_reg, s16_fsq_next;
    logic [75:0]      s17_ne_reg, s17_ne_next, s17_nf_reg, s17_nf_next;

    logic               sq3_v;
    logic [1:0][37:0]   sq3_root;
    logic [CTX_W-1:0]   sq3_side;
    hsc_ctx_t           ctx_c;
    logic [2:0][50:0]   dv3_num;

    logic               dv3_v;
    logic [2:0][15:0]   dv3_quot;
    logic [CTX_W-1:0]   dv3_side;

    logic               m_valid_reg;
    hsc_out_t           m_data_reg, m_data_next;

    // The pipe moves whenever the output register can take a new beat.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg  <= '0;
            radius_reg  <= RADIUS_RST;
            hdir_reg[0] <= '0;
            hdir_reg[1] <= '0;
            hdir_reg[2] <= ONE_Q14;
            cos_reg     <= ONE_Q14;
        end else if (cfg_wr_en) begin
            case (hsc_reg_t'(cfg_index))
                REG_CENTER_X: center_reg[0] <= cfg_wdata;
                REG_CENTER_Y: center_reg[1] <= cfg_wdata;
                REG_CENTER_Z: center_reg[2] <= cfg_wdata;
                REG_RADIUS:   radius_reg    <= cfg_wdata[30:0];
                REG_HOLE_X:   hdir_reg[0]   <= cfg_wdata[15:0];
                REG_HOLE_Y:   hdir_reg[1]   <= cfg_wdata[15:0];
                REG_HOLE_Z:   hdir_reg[2]   <= cfg_wdata[15:0];
                REG_COS_HOLE: cos_reg       <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Offset from center, its squares and their sum; sine radicand alongside.
    always_comb begin
        logic signed [32:0] rem;
        pt[0] = s_data.point_x;
        pt[1] = s_data.point_y;
        pt[2] = s_data.point_z;
        for (int i = 0; i < 3; i++) begin
            s1_d_next[i]  = {pt[i][31], pt[i]} - {center_reg[i][31], center_reg[i]};
            s2_sq_next[i] = 66'($signed(s1_d_reg[i]) * $signed(s1_d_reg[i]));
        end
        s2_chsq_next = 32'($signed(cos_reg) * $signed(cos_reg));
        s3_n_next = 68'(s2_sq_reg[0]) + 68'(s2_sq_reg[1]) + 68'(s2_sq_reg[2]);
        rem = ONE_SQ_Q28 - $signed({1'b0, s2_chsq_reg});
        s3_srem_next = (rem > 33'sd0) ? 68'(rem) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_d_reg    <= s1_d_next;
            s2_d_reg    <= s1_d_reg;
            s2_sq_reg   <= s2_sq_next;
            s2_chsq_reg <= s2_chsq_next;
            s3_d_reg    <= s2_d_reg;
            s3_n_reg    <= s3_n_next;
            s3_srem_reg <= s3_srem_next;
        end
    end

    // Length of the offset and sine of the hole angle.
    hsc_sqrt_pipe #(.NW(68), .LANES(2), .SIDE_W(99)) u_sqrt_len (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s3_v_reg), .rad({s3_srem_reg, s3_n_reg}), .in_side(s3_d_reg),
        .out_valid(sq1_v), .root(sq1_root), .out_side(sq1_side)
    );

    always_comb begin
        ctx_a       = '0;
        ctx_a.d     = sq1_side;
        ctx_a.len   = sq1_root[0];
        ctx_a.s     = sq1_root[1][14:0];
        ctx_a.degen = (sq1_root[0] == '0);
    end

    // Unit direction u = d / len.
    hsc_div_pipe #(.NUM_W(47), .DEN_W(34), .Q_W(15), .LANES(3), .SIDE_W(CTX_W)) u_div_dir (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(sq1_v),
        .num({{ctx_a.d[2], 14'd0}, {ctx_a.d[1], 14'd0}, {ctx_a.d[0], 14'd0}}),
        .den(ctx_a.len), .in_side(ctx_a),
        .out_valid(dv1_v), .quot(dv1_quot), .out_side(dv1_side)
    );

    // Dot product with the axis, cone test, tangent vector and its squared length.
    always_comb begin
        logic signed [33:0] chk;
        s5_ctx_next   = hsc_ctx_t'(dv1_side);
        s5_ctx_next.u = dv1_quot;
        for (int i = 0; i < 3; i++) begin
            s5_prod_next[i] = 32'($signed(dv1_quot[i]) * $signed(hdir_reg[i]));
        end
        s6_dot_next = 34'($signed(s5_prod_reg[0])) + 34'($signed(s5_prod_reg[1]))
                    + 34'($signed(s5_prod_reg[2]));
        chk = $signed({{4{cos_reg[15]}}, cos_reg, 14'd0});
        s7_ctx_next      = s6_ctx_reg;
        s7_ctx_next.hole = (chk < $signed(s6_dot_reg));
        s7_ctx_next.c14  = 20'(rnd_q14(64'($signed(s6_dot_reg))));
        s7_ctx_next.clr0 = $signed({5'd0, radius_reg}) - $signed({2'd0, s6_ctx_reg.len});
        for (int i = 0; i < 3; i++) begin
            s8_uu_next[i] = {{5{s7_ctx_reg.u[i][15]}}, s7_ctx_reg.u[i], 14'd0};
            s8_ch_next[i] = 36'($signed(s7_ctx_reg.c14) * $signed(hdir_reg[i]));
        end
        s9_ctx_next = s8_ctx_reg;
        for (int i = 0; i < 3; i++) begin
            s9_ctx_next.tv[i] = s8_uu_reg[i] - s8_ch_reg[i][34:0];
            s10_sq_next[i]    = 70'($signed(s9_ctx_reg.tv[i]) * $signed(s9_ctx_reg.tv[i]));
        end
        s11_n_next = 72'(s10_sq_reg[0]) + 72'(s10_sq_reg[1]) + 72'(s10_sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_ctx_reg  <= s5_ctx_next;
            s5_prod_reg <= s5_prod_next;
            s6_ctx_reg  <= s5_ctx_reg;
            s6_dot_reg  <= s6_dot_next;
            s7_ctx_reg  <= s7_ctx_next;
            s8_ctx_reg  <= s7_ctx_reg;
            s8_uu_reg   <= s8_uu_next;
            s8_ch_reg   <= s8_ch_next;
            s9_ctx_reg  <= s9_ctx_next;
            s10_ctx_reg <= s9_ctx_reg;
            s10_sq_reg  <= s10_sq_next;
            s11_ctx_reg <= s10_ctx_reg;
            s11_n_reg   <= s11_n_next;
        end
    end

    // Length of the tangent vector.
    hsc_sqrt_pipe #(.NW(72), .LANES(1), .SIDE_W(CTX_W)) u_sqrt_tan (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s11_v_reg), .rad(s11_n_reg), .in_side(s11_ctx_reg),
        .out_valid(sq2_v), .root(sq2_root), .out_side(sq2_side)
    );

    always_comb begin
        ctx_b = hsc_ctx_t'(sq2_side);
        for (int i = 0; i < 3; i++) begin
            dv2_num[i] = {ctx_b.tv[i], 14'd0};
        end
    end

    // Unit tangent t.
    hsc_div_pipe #(.NUM_W(49), .DEN_W(36), .Q_W(15), .LANES(3), .SIDE_W(CTX_W)) u_div_tan (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(sq2_v),
        .num(dv2_num), .den(sq2_root[0]), .in_side(ctx_b),
        .out_valid(dv2_v), .quot(dv2_quot), .out_side(dv2_side)
    );

    // Rim direction w, offsets e (from rim) and f (from pole), their squared lengths.
    always_comb begin
        s12_ctx_next   = hsc_ctx_t'(dv2_side);
        s12_ctx_next.t = dv2_quot;
        for (int i = 0; i < 3; i++) begin
            s12_m1_next[i] = 32'($signed(cos_reg) * $signed(hdir_reg[i]));
            s12_m2_next[i] = 32'($signed({1'b0, s12_ctx_next.s}) * $signed(dv2_quot[i]));
            s13_w_next[i]  = 20'(rnd_q14(64'($signed(s12_m1_reg[i]))
                                       + 64'($signed(s12_m2_reg[i]))));
            s14_rw_next[i] = 52'($signed({1'b0, radius_reg}) * $signed(s13_w_reg[i]));
            s14_rh_next[i] = 48'($signed({1'b0, radius_reg}) * $signed(hdir_reg[i]));
        end
        s15_ctx_next = s14_ctx_reg;
        for (int i = 0; i < 3; i++) begin
            s15_ctx_next.e[i] = 37'(64'($signed(s14_ctx_reg.d[i]))
                                    - rnd_q14(64'($signed(s14_rw_reg[i]))));
            s15_f_next[i]     = 37'(64'($signed(s14_ctx_reg.d[i]))
                                    - rnd_q14(64'($signed(s14_rh_reg[i]))));
            s16_esq_next[i]   = 74'($signed(s15_ctx_reg.e[i]) * $signed(s15_ctx_reg.e[i]));
            s16_fsq_next[i]   = 74'($signed(s15_f_reg[i]) * $signed(s15_f_reg[i]));
        end
        s17_ne_next = 76'(s16_esq_reg[0]) + 76'(s16_esq_reg[1]) + 76'(s16_esq_reg[2]);
        s17_nf_next = 76'(s16_fsq_reg[0]) + 76'(s16_fsq_reg[1]) + 76'(s16_fsq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s12_ctx_reg <= s12_ctx_next;
            s12_m1_reg  <= s12_m1_next;
            s12_m2_reg  <= s12_m2_next;
            s13_ctx_reg <= s12_ctx_reg;
            s13_w_reg   <= s13_w_next;
            s14_ctx_reg <= s13_ctx_reg;
            s14_rw_reg  <= s14_rw_next;
            s14_rh_reg  <= s14_rh_next;
            s15_ctx_reg <= s15_ctx_next;
            s15_f_reg   <= s15_f_next;
            s16_ctx_reg <= s15_ctx_reg;
            s16_esq_reg <= s16_esq_next;
            s16_fsq_reg <= s16_fsq_next;
            s17_ctx_reg <= s16_ctx_reg;
            s17_ne_reg  <= s17_ne_next;
            s17_nf_reg  <= s17_nf_next;
        end
    end

    // Lengths of e and f.
    hsc_sqrt_pipe #(.NW(76), .LANES(2), .SIDE_W(CTX_W)) u_sqrt_rim (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s17_v_reg), .rad({s17_nf_reg, s17_ne_reg}), .in_side(s17_ctx_reg),
        .out_valid(sq3_v), .root(sq3_root), .out_side(sq3_side)
    );

    always_comb begin
        ctx_c      = hsc_ctx_t'(sq3_side);
        ctx_c.lenf = sq3_root[1];
        for (int i = 0; i < 3; i++) begin
            dv3_num[i] = {ctx_c.e[i], 14'd0};
        end
    end

    // Hole normal = e / |e|.
    hsc_div_pipe #(.NUM_W(51), .DEN_W(38), .Q_W(15), .LANES(3), .SIDE_W(CTX_W)) u_div_rim (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(sq3_v),
        .num(dv3_num), .den(sq3_root[0]), .in_side(ctx_c),
        .out_valid(dv3_v), .quot(dv3_quot), .out_side(dv3_side)
    );

    // Result selection and saturation.
    always_comb begin
        hsc_ctx_t cx;
        cx = hsc_ctx_t'(dv3_side);
        m_data_next = '0;
        if (cx.degen) begin
            m_data_next.degenerate = 1'b1;
        end else if (cx.hole) begin
            m_data_next.in_hole  = 1'b1;
            m_data_next.normal_x = dv3_quot[0];
            m_data_next.normal_y = dv3_quot[1];
            m_data_next.normal_z = dv3_quot[2];
            if (cx.lenf > 38'd2147483647) begin
                m_data_next.clearance = 32'sh7fffffff;
            end else begin
                m_data_next.clearance = cx.lenf[31:0];
            end
        end else begin
            m_data_next.normal_x = 16'(-$signed(cx.u[0]));
            m_data_next.normal_y = 16'(-$signed(cx.u[1]));
            m_data_next.normal_z = 16'(-$signed(cx.u[2]));
            if ($signed(cx.clr0) > 36'sd2147483647) begin
                m_data_next.clearance = 32'sh7fffffff;
            end else if ($signed(cx.clr0) < -36'sd2147483648) begin
                m_data_next.clearance = 32'sh80000000;
            end else begin
                m_data_next.clearance = cx.clr0[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    // Valid bits of the glue stages and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s5_v_reg    <= 1'b0;
            s6_v_reg    <= 1'b0;
            s7_v_reg    <= 1'b0;
            s8_v_reg    <= 1'b0;
            s9_v_reg    <= 1'b0;
            s10_v_reg   <= 1'b0;
            s11_v_reg   <= 1'b0;
            s12_v_reg   <= 1'b0;
            s13_v_reg   <= 1'b0;
            s14_v_reg   <= 1'b0;
            s15_v_reg   <= 1'b0;
            s16_v_reg   <= 1'b0;
            s17_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg    <= s_valid;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s5_v_reg    <= dv1_v;
            s6_v_reg    <= s5_v_reg;
            s7_v_reg    <= s6_v_reg;
            s8_v_reg    <= s7_v_reg;
            s9_v_reg    <= s8_v_reg;
            s10_v_reg   <= s9_v_reg;
            s11_v_reg   <= s10_v_reg;
            s12_v_reg   <= dv2_v;
            s13_v_reg   <= s12_v_reg;
            s14_v_reg   <= s13_v_reg;
            s15_v_reg   <= s14_v_reg;
            s16_v_reg   <= s15_v_reg;
            s17_v_reg   <= s16_v_reg;
            m_valid_reg <= dv3_v;
        end
    end

`ifndef SYNTHESIS
    // A degenerate beat carries nothing but its flag.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.clearance == 32'sd0 && !m_data.in_hole && m_data.normal_x == 16'sd0
            && m_data.normal_y == 16'sd0 && m_data.normal_z == 16'sd0)
        else $error("degenerate result with nonzero fields");

    // Normal components never exceed one in Q2.14.
    a_norm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            $signed(m_data.normal_x) <= 16'sd16384 && $signed(m_data.normal_x) >= -16'sd16384
            && $signed(m_data.normal_y) <= 16'sd16384 && $signed(m_data.normal_y) >= -16'sd16384
            && $signed(m_data.normal_z) <= 16'sd16384 && $signed(m_data.normal_z) >= -16'sd16384)
        else $error("normal component out of range");

    // A stalled pipe keeps its valid bits.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s1_v_reg) && $stable(s9_v_reg) && $stable(s17_v_reg))
        else $error("pipeline moved during a stall");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");
`endif

endmodule

### sv/hsc_sqrt_pipe.sv
module hsc_sqrt_pipe #(
    parameter int NW     = 68,
    parameter int LANES  = 2,
    parameter int SIDE_W = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [LANES-1:0][NW-1:0]       rad,
    input  logic [SIDE_W-1:0]              in_side,
    output logic                           out_valid,
    output logic [LANES-1:0][NW/2-1:0]     root,
    output logic [SIDE_W-1:0]              out_side
);

    localparam int RW = NW / 2;
    localparam logic [NW-1:0] ONE_V = NW'(1);

    logic [RW-1:0]     v_reg;
    logic [SIDE_W-1:0] side_reg [RW];
    logic [NW-1:0]     x_reg    [RW][LANES];
    logic [NW-1:0]     r_reg    [RW][LANES];
    logic [NW-1:0]     x_src    [RW][LANES];
    logic [NW-1:0]     r_src    [RW][LANES];
    logic [NW-1:0]     x_next   [RW][LANES];
    logic [NW-1:0]     r_next   [RW][LANES];

    // Operands of each stage: the ports for the first, the previous stage otherwise.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            x_src[0][l] = rad[l];
            r_src[0][l] = '0;
        end
        for (int k = 1; k < RW; k++) begin
            for (int l = 0; l < LANES; l++) begin
                x_src[k][l] = x_reg[k-1][l];
                r_src[k][l] = r_reg[k-1][l];
            end
        end
    end

    // One root bit per stage: trial subtract of root plus the current bit weight.
    always_comb begin
        logic [NW-1:0] trial;
        for (int k = 0; k < RW; k++) begin
            for (int l = 0; l < LANES; l++) begin
                trial = r_src[k][l] + (ONE_V << (2 * (RW - 1 - k)));
                if (x_src[k][l] >= trial) begin
                    x_next[k][l] = x_src[k][l] - trial;
                    r_next[k][l] = (r_src[k][l] >> 1) + (ONE_V << (2 * (RW - 1 - k)));
                end else begin
                    x_next[k][l] = x_src[k][l];
                    r_next[k][l] = r_src[k][l] >> 1;
                end
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[RW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < RW; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < RW; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    x_reg[k][l] <= x_next[k][l];
                    r_reg[k][l] <= r_next[k][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            root[l] = r_reg[RW-1][l][RW-1:0];
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

### sv/hsc_div_pipe.sv
module hsc_div_pipe #(
    parameter int NUM_W  = 47,
    parameter int DEN_W  = 34,
    parameter int Q_W    = 15,
    parameter int LANES  = 3,
    parameter int SIDE_W = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]            den,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W:0]     quot,
    output logic [SIDE_W-1:0]           out_side
);

    localparam int MAG_W = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
    localparam int REM_W = MAG_W + Q_W;
    localparam int NST   = Q_W + 2;

    logic [NST-1:0]          v_reg;
    logic [SIDE_W-1:0]       side_reg [NST];
    logic [MAG_W-1:0]        rem_reg  [Q_W][LANES];
    logic [Q_W-1:0]          q_reg    [Q_W+1][LANES];
    logic [LANES-1:0]        neg_reg  [Q_W+1];
    logic                    zero_reg [Q_W+1];
    logic [DEN_W-1:0]        den_reg  [Q_W];
    logic [LANES-1:0][Q_W:0] quot_reg;

    logic [MAG_W-1:0]        prep_next [LANES];
    logic [MAG_W-1:0]        rem_next  [Q_W][LANES];
    logic [Q_W-1:0]          q_next    [Q_W][LANES];
    logic [LANES-1:0][Q_W:0] quot_next;

    // Entry: magnitude plus half the divisor gives rounding half away from zero.
    always_comb begin
        logic [NUM_W-1:0] mag;
        for (int l = 0; l < LANES; l++) begin
            mag = num[l][NUM_W-1] ? (~num[l] + NUM_W'(1)) : num[l];
            prep_next[l] = MAG_W'(mag) + MAG_W'(den >> 1);
        end
    end

    // One quotient bit per stage, restoring.
    always_comb begin
        logic [REM_W-1:0] dsh;
        logic [REM_W-1:0] rwide;
        for (int k = 0; k < Q_W; k++) begin
            for (int l = 0; l < LANES; l++) begin
                dsh   = REM_W'(den_reg[k]) << (Q_W - 1 - k);
                rwide = REM_W'(rem_reg[k][l]);
                if (rwide >= dsh) begin
                    rem_next[k][l] = MAG_W'(rwide - dsh);
                    q_next[k][l]   = q_reg[k][l] | (Q_W'(1) << (Q_W - 1 - k));
                end else begin
                    rem_next[k][l] = rem_reg[k][l];
                    q_next[k][l]   = q_reg[k][l];
                end
            end
        end
    end

    // Sign back on; a zero divisor yields zero.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (zero_reg[Q_W]) begin
                quot_next[l] = '0;
            end else if (neg_reg[Q_W][l]) begin
                quot_next[l] = (Q_W+1)'(-$signed({1'b0, q_reg[Q_W][l]}));
            end else begin
                quot_next[l] = {1'b0, q_reg[Q_W][l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 1; k < NST; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= prep_next[l];
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= num[l][NUM_W-1];
            end
            zero_reg[0] <= (den == '0);
            den_reg[0]  <= den;
            for (int k = 0; k < Q_W; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    q_reg[k+1][l] <= q_next[k][l];
                end
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
            end
            for (int k = 0; k < Q_W - 1; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k+1][l] <= rem_next[k][l];
                end
                den_reg[k+1] <= den_reg[k];
            end
            quot_reg <= quot_next;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_side  = side_reg[NST-1];
    assign quot      = quot_reg;

endmodule
